### src/lasf_pkg.sv
package lasf_pkg;

  localparam logic [7:0] CH_DASH = 8'h2D;
  localparam logic [7:0] CH_ANY  = 8'h4E;

  localparam logic OP_QUERY   = 1'b0;
  localparam logic OP_SUBJECT = 1'b1;

  localparam logic [1:0] REG_MATCH    = 2'd0;
  localparam logic [1:0] REG_MISMATCH = 2'd1;
  localparam logic [1:0] REG_GAP      = 2'd2;
  localparam logic [1:0] REG_GAP_OPEN = 2'd3;

  typedef enum logic [1:0] {
    MV_BOUND = 2'd0,
    MV_DIAG  = 2'd1,
    MV_VERT  = 2'd2,
    MV_HORIZ = 2'd3
  } move_t;

  typedef struct packed {
    logic signed [7:0] match_score;
    logic signed [7:0] mismatch_score;
    logic signed [7:0] gap_score;
    logic signed [7:0] gap_open_score;
  } cfg_t;

  typedef struct packed {
    logic       op;
    logic [7:0] base;
    logic       last;
  } in_t;

  typedef struct packed {
    logic [15:0] best_score;
    logic [12:0] best_subject_pos;
    logic [8:0]  best_query_pos;
    logic        overflow;
  } out_t;

endpackage

### src/lasf_cell.sv
module lasf_cell #(
  parameter int SW  = 16,
  parameter int CW  = 9,
  parameter int COL = 1
) (
  input  logic               clk,
  input  logic               rst,
  input  lasf_pkg::cfg_t     cfg,
  input  logic               clear,
  input  logic               load_en,
  input  logic [7:0]         load_base,
  input  logic               en,
  input  logic               tin_valid,
  input  logic [7:0]         tin_sb,
  input  logic [SW-1:0]      tin_diag,
  input  logic [SW-1:0]      tin_left,
  input  lasf_pkg::move_t    tin_left_m,
  input  logic [SW-1:0]      tin_best,
  input  logic [CW-1:0]      tin_col,
  output logic               tout_valid,
  output logic [7:0]         tout_sb,
  output logic [SW-1:0]      tout_diag,
  output logic [SW-1:0]      tout_left,
  output lasf_pkg::move_t    tout_left_m,
  output logic [SW-1:0]      tout_best,
  output logic [CW-1:0]      tout_col
);

  localparam int EW = SW + 2;
  localparam logic signed [EW-1:0] CAP = EW'((64'd1 << SW) - 64'd1);

  logic [7:0]             q;
  logic [SW-1:0]          up_s;
  lasf_pkg::move_t        up_m;
  logic [SW-1:0]          up_use;
  lasf_pkg::move_t        up_m_use;
  logic signed [7:0]      pair;
  logic signed [EW-1:0]   d, h, v, best, cell_full;
  logic [SW-1:0]          cell_sat;
  lasf_pkg::move_t        mv;

  // a row launched in the clearing cycle must see the cleared upper cell
  assign up_use   = clear ? '0 : up_s;
  assign up_m_use = clear ? lasf_pkg::MV_BOUND : up_m;

  always_comb begin
    if (tin_sb == lasf_pkg::CH_DASH || q == lasf_pkg::CH_DASH) begin
      pair = cfg.gap_score;
    end else if (tin_sb == lasf_pkg::CH_ANY || q == lasf_pkg::CH_ANY || tin_sb == q) begin
      pair = cfg.match_score;
    end else begin
      pair = cfg.mismatch_score;
    end
    d = $signed({2'b00, tin_diag}) + EW'(pair);
    h = $signed({2'b00, up_use}) + EW'(cfg.gap_score)
        + ((up_m_use != lasf_pkg::MV_HORIZ) ? EW'(cfg.gap_open_score) : EW'(0));
    v = $signed({2'b00, tin_left}) + EW'(cfg.gap_score)
        + ((tin_left_m != lasf_pkg::MV_VERT) ? EW'(cfg.gap_open_score) : EW'(0));
    best = d;
    if (best < h) best = h;
    if (best < v) best = v;
    if (best < 0) best = '0;
    if (d == best) begin
      cell_full = d; mv = lasf_pkg::MV_DIAG;
    end else if (v == best) begin
      cell_full = v; mv = lasf_pkg::MV_VERT;
    end else if (h == best) begin
      cell_full = h; mv = lasf_pkg::MV_HORIZ;
    end else begin
      cell_full = '0; mv = lasf_pkg::MV_BOUND;
    end
    cell_sat = (cell_full > CAP) ? CAP[SW-1:0] : cell_full[SW-1:0];
  end

  always_ff @(posedge clk) begin
    if (load_en) begin
      q <= load_base;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      up_s <= '0;
      up_m <= lasf_pkg::MV_BOUND;
    end else if (tin_valid && en) begin
      up_s <= cell_sat;
      up_m <= mv;
    end else if (clear) begin
      up_s <= '0;
      up_m <= lasf_pkg::MV_BOUND;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tout_valid <= 1'b0;
    end else begin
      tout_valid <= tin_valid;
    end
  end

  // token moves one cell per cycle; disabled columns pass it unchanged
  always_ff @(posedge clk) begin
    tout_sb <= tin_sb;
    if (en) begin
      tout_diag   <= up_use;
      tout_left   <= cell_sat;
      tout_left_m <= mv;
      if (cell_sat > tin_best) begin
        tout_best <= cell_sat;
        tout_col  <= CW'(COL);
      end else begin
        tout_best <= tin_best;
        tout_col  <= tin_col;
      end
    end else begin
      tout_diag   <= tin_diag;
      tout_left   <= tin_left;
      tout_left_m <= tin_left_m;
      tout_best   <= tin_best;
      tout_col    <= tin_col;
    end
  end

endmodule

### src/local_alignment_score_fill_unit.sv
// Local-alignment score fill.
// Input channel (in_valid/in_stall/in_data): op 0 appends a query base to the
// cell row, op 1 runs one subject base through the row. Query base transfers
// do not raise in_stall. A subject row sends a token down a chain of
// MAX_QUERY cells, one cell per cycle; the length of the cell chain sets how
// long a row takes. in_stall is high while a row is in flight. After the
// subject base marked last, one result (best score and its one-based subject
// row and query column, overflow) is loaded into the output register in state
// S_FIN, which follows the completed row, and the next item is taken once the
// block is back in S_IDLE. If the receiver stalls, the result holds in the
// output register; a later result waits in the block with in_stall high until
// the held one is taken. Configuration (cfg_wr_en/cfg_index/cfg_data) is to
// be written while idle; the block does not enforce this. Reset (rst,
// synchronous) restores the register defaults, empties the query and clears
// the output; the row state clears at each alignment start.
module local_alignment_score_fill_unit #(
  parameter int MAX_QUERY   = 256,
  parameter int MAX_SUBJECT = 4096,
  parameter int SCORE_WIDTH = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_wr_en,
  input  logic [1:0]      cfg_index,
  input  logic [7:0]      cfg_data,
  input  logic            in_valid,
  output logic            in_stall,
  input  lasf_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output lasf_pkg::out_t  out_data
);

  localparam int SW  = SCORE_WIDTH;
  localparam int CW  = $clog2(MAX_QUERY + 1);
  localparam int SCW = $clog2(MAX_SUBJECT + 1);
  localparam int OW  = (SW > 16) ? SW : 16;

  typedef enum logic [1:0] {S_IDLE, S_ROW, S_FIN} state_t;

  state_t          state;
  lasf_pkg::cfg_t  cfg;
  logic [CW-1:0]   qcnt;
  logic [SCW-1:0]  scount;
  logic [SW-1:0]   top_score;
  logic [SCW-1:0]  top_row;
  logic [CW-1:0]   top_col;
  logic            dropped;
  logic            phase;
  logic            pend_last;
  logic            launch;
  logic            clear;
  logic            accept;
  logic [OW-1:0]   top_wide;

  logic                  tv   [0:MAX_QUERY];
  logic [7:0]            tsb  [0:MAX_QUERY];
  logic [SW-1:0]         tdg  [0:MAX_QUERY];
  logic [SW-1:0]         tlf  [0:MAX_QUERY];
  lasf_pkg::move_t       tlm  [0:MAX_QUERY];
  logic [SW-1:0]         tbs  [0:MAX_QUERY];
  logic [CW-1:0]         tcl  [0:MAX_QUERY];

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign clear    = accept && !phase &&
                    ((in_data.op == lasf_pkg::OP_SUBJECT) || in_data.last);
  assign launch   = accept && (in_data.op == lasf_pkg::OP_SUBJECT) &&
                    (scount < SCW'(MAX_SUBJECT));

  assign tv[0]  = launch;
  assign tsb[0] = in_data.base;
  assign tdg[0] = '0;
  assign tlf[0] = '0;
  assign tlm[0] = lasf_pkg::MV_BOUND;
  assign tbs[0] = '0;
  assign tcl[0] = '0;

  for (genvar j = 0; j < MAX_QUERY; j++) begin : g_cell
    lasf_cell #(.SW(SW), .CW(CW), .COL(j + 1)) u_cell (
      .clk        (clk),
      .rst        (rst),
      .cfg        (cfg),
      .clear      (clear),
      .load_en    (accept && in_data.op == lasf_pkg::OP_QUERY && !phase &&
                   qcnt == CW'(j)),
      .load_base  (in_data.base),
      .en         (CW'(j) < qcnt),
      .tin_valid  (tv[j]),
      .tin_sb     (tsb[j]),
      .tin_diag   (tdg[j]),
      .tin_left   (tlf[j]),
      .tin_left_m (tlm[j]),
      .tin_best   (tbs[j]),
      .tin_col    (tcl[j]),
      .tout_valid (tv[j+1]),
      .tout_sb    (tsb[j+1]),
      .tout_diag  (tdg[j+1]),
      .tout_left  (tlf[j+1]),
      .tout_left_m(tlm[j+1]),
      .tout_best  (tbs[j+1]),
      .tout_col   (tcl[j+1])
    );
  end

  assign top_wide = OW'(top_score);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cfg       <= '{match_score: 8'sd2, mismatch_score: -8'sd1,
                     gap_score: -8'sd1, gap_open_score: 8'sd0};
      qcnt      <= '0;
      scount    <= '0;
      top_score <= '0;
      top_row   <= '0;
      top_col   <= '0;
      dropped   <= 1'b0;
      phase     <= 1'b0;
      pend_last <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          lasf_pkg::REG_MATCH:    cfg.match_score    <= cfg_data;
          lasf_pkg::REG_MISMATCH: cfg.mismatch_score <= cfg_data;
          lasf_pkg::REG_GAP:      cfg.gap_score      <= cfg_data;
          lasf_pkg::REG_GAP_OPEN: cfg.gap_open_score <= cfg_data;
          default: ;
        endcase
      end
      // S_FIN reloads the output register itself
      if (out_valid && !out_stall && state != S_FIN) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (in_data.op == lasf_pkg::OP_QUERY) begin
              if (!phase) begin
                if (qcnt < CW'(MAX_QUERY)) qcnt <= qcnt + 1'b1;
                else dropped <= 1'b1;
                if (in_data.last) begin
                  phase     <= 1'b1;
                  scount    <= '0;
                  top_score <= '0;
                  top_row   <= '0;
                  top_col   <= '0;
                end
              end
            end else begin
              phase     <= 1'b1;
              pend_last <= in_data.last;
              if (!phase) begin
                top_score <= '0;
                top_row   <= '0;
                top_col   <= '0;
              end
              if (launch) begin
                scount <= phase ? scount + 1'b1 : SCW'(1);
                state  <= S_ROW;
              end else begin
                dropped <= 1'b1;
                if (in_data.last) state <= S_FIN;
              end
            end
          end
        end
        S_ROW: begin
          if (tv[MAX_QUERY]) begin
            if (tbs[MAX_QUERY] > top_score) begin
              top_score <= tbs[MAX_QUERY];
              top_row   <= scount;
              top_col   <= tcl[MAX_QUERY];
            end
            state <= pend_last ? S_FIN : S_IDLE;
          end
        end
        S_FIN: begin
          if (!out_valid || !out_stall) begin
            out_valid                 <= 1'b1;
            out_data.best_score       <= (top_wide > OW'(16'hFFFF)) ? 16'hFFFF
                                                                   : top_wide[15:0];
            out_data.best_subject_pos <= 13'(top_row);
            out_data.best_query_pos   <= 9'(top_col);
            out_data.overflow         <= dropped;
            qcnt    <= '0;
            scount  <= '0;
            dropped <= 1'b0;
            phase   <= 1'b0;
            state   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_token_in_row: assert property (@(posedge clk) disable iff (rst)
    tv[MAX_QUERY] |-> state == S_ROW)
    else $error("row token left the chain outside a row");

  a_qcnt_range: assert property (@(posedge clk) disable iff (rst)
    qcnt <= CW'(MAX_QUERY))
    else $error("query count beyond capacity");

  a_fin_ends: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && (!out_valid || !out_stall)) |=> (!phase && out_valid))
    else $error("result transfer did not close the alignment");

  a_launch_idle: assert property (@(posedge clk) disable iff (rst)
    launch |=> state == S_ROW)
    else $error("row launched without entering row state");

endmodule

### sim/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QMAX = 256;
  localparam int SMAX = 4096;
  localparam int ROW_CYCLES = QMAX + 2;
  localparam int IDLE_LIMIT = 20000;

  // Expected alignment results, computed as subject transfers are accepted.
  class align_scoreboard;
    logic signed [7:0] score_reg [4];
    logic [7:0] query [QMAX];
    int unsigned qcount, scount;
    longint cells [QMAX];
    lasf_pkg::move_t moves [QMAX];
    longint top_score;
    int unsigned top_row, top_col;
    bit dropped, aligning;
    lasf_pkg::out_t pending [$];
    int errors;

    function void reset_state();
      score_reg[lasf_pkg::REG_MATCH] = 8'sd2;
      score_reg[lasf_pkg::REG_MISMATCH] = -8'sd1;
      score_reg[lasf_pkg::REG_GAP] = -8'sd1;
      score_reg[lasf_pkg::REG_GAP_OPEN] = 8'sd0;
      qcount = 0; scount = 0; dropped = 0; aligning = 0;
      top_score = 0; top_row = 0; top_col = 0;
      errors = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [7:0] val);
      score_reg[idx] = val;
    endfunction

    function void start_alignment();
      for (int j = 0; j < QMAX; j++) begin
        cells[j] = 0;
        moves[j] = lasf_pkg::MV_BOUND;
      end
      scount = 0; top_score = 0; top_row = 0; top_col = 0;
      aligning = 1;
    endfunction

    function longint pair_value(logic [7:0] a, logic [7:0] b);
      if (a == lasf_pkg::CH_DASH || b == lasf_pkg::CH_DASH)
        return score_reg[lasf_pkg::REG_GAP];
      if (a == lasf_pkg::CH_ANY || b == lasf_pkg::CH_ANY || a == b)
        return score_reg[lasf_pkg::REG_MATCH];
      return score_reg[lasf_pkg::REG_MISMATCH];
    endfunction

    function void fill_row(logic [7:0] sb);
      longint diag_s, left_s, up_s, d, h, v, best, cval;
      longint gap, gopen;
      lasf_pkg::move_t left_m, mv;
      diag_s = 0; left_s = 0; left_m = lasf_pkg::MV_BOUND;
      gap = score_reg[lasf_pkg::REG_GAP];
      gopen = score_reg[lasf_pkg::REG_GAP_OPEN];
      scount++;
      for (int j = 0; j < qcount; j++) begin
        up_s = cells[j];
        d = diag_s + pair_value(sb, query[j]);
        h = up_s + gap + ((moves[j] != lasf_pkg::MV_HORIZ) ? gopen : 0);
        v = left_s + gap + ((left_m != lasf_pkg::MV_VERT) ? gopen : 0);
        best = d;
        if (best < h) best = h;
        if (best < v) best = v;
        if (best < 0) best = 0;
        if (d == best) begin cval = d; mv = lasf_pkg::MV_DIAG; end
        else if (v == best) begin cval = v; mv = lasf_pkg::MV_VERT; end
        else if (h == best) begin cval = h; mv = lasf_pkg::MV_HORIZ; end
        else begin cval = 0; mv = lasf_pkg::MV_BOUND; end
        if (cval > 65535) cval = 65535;
        diag_s = up_s;
        cells[j] = cval;
        moves[j] = mv;
        left_s = cval;
        left_m = mv;
        if (cval > top_score) begin
          top_score = cval; top_row = scount; top_col = j + 1;
        end
      end
    endfunction

    function void note_input(lasf_pkg::in_t it);
      lasf_pkg::out_t r;
      if (it.op == lasf_pkg::OP_QUERY) begin
        if (aligning) return;
        if (qcount < QMAX) begin
          query[qcount] = it.base;
          qcount++;
        end else dropped = 1;
        if (it.last) start_alignment();
        return;
      end
      if (!aligning) start_alignment();
      if (scount < SMAX) fill_row(it.base);
      else dropped = 1;
      if (!it.last) return;
      r.best_score = top_score[15:0];
      r.best_subject_pos = top_row[12:0];
      r.best_query_pos = top_col[8:0];
      r.overflow = dropped;
      pending = {pending, r};
      qcount = 0; scount = 0; dropped = 0; aligning = 0;
    endfunction

    function void check_result(lasf_pkg::out_t got);
      lasf_pkg::out_t exp_r;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", got);
        return;
      end
      exp_r = pending.pop_front();
      if (got.best_score !== exp_r.best_score ||
          got.best_subject_pos !== exp_r.best_subject_pos ||
          got.best_query_pos !== exp_r.best_query_pos ||
          got.overflow !== exp_r.overflow) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp score %0d row %0d col %0d ovf %0b, got %0d %0d %0d %0b",
                   exp_r.best_score, exp_r.best_subject_pos, exp_r.best_query_pos,
                   exp_r.overflow, got.best_score, got.best_subject_pos,
                   got.best_query_pos, got.overflow);
      end
    endfunction
  endclass

  logic clk, rst;
  logic cfg_wr_en;
  logic [1:0] cfg_index;
  logic [7:0] cfg_data;
  logic in_valid, in_stall, out_valid, out_stall;
  lasf_pkg::in_t in_data;
  lasf_pkg::out_t out_data;

  align_scoreboard sb;
  int idle_cycles;
  bit stall_on;
  int stall_mode;
  int burst_left, gap_left;

  local_alignment_score_fill_unit DUT (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    sb = new();
    sb.reset_state();
  end

  // Result side: stall pattern changes mode now and then; mode 0 never stalls.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 0;
      stall_mode <= 0;
    end else begin
      if (out_valid && !out_stall) sb.check_result(out_data);
      if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
      case (stall_mode)
        0: out_stall <= 0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        default: out_stall <= ($urandom_range(0, 9) < 7);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic write_cfg(logic [1:0] idx, logic [7:0] val);
    cfg_wr_en <= 1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
    cfg_wr_en <= 0;
    @(posedge clk);
  endtask

  // One transfer, with burst/gap pacing before raising valid. Valid stays up
  // across a burst; drain() drops it at the end of a sequence.
  task automatic send(logic op, logic [7:0] base, logic last);
    lasf_pkg::in_t it;
    if (burst_left == 0) begin
      gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 12);
      if (gap_left > 0) begin
        in_valid <= 0;
        repeat (gap_left) @(posedge clk);
      end
    end
    burst_left--;
    it.op = op; it.base = base; it.last = last;
    in_valid <= 1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    sb.note_input(it);
  endtask

  function automatic logic [7:0] rand_base(int alpha);
    logic [7:0] letters [6] = '{"A", "C", "G", "T", lasf_pkg::CH_ANY, lasf_pkg::CH_DASH};
    if (alpha == 0) return 8'($urandom_range(0, 255));
    return letters[$urandom_range(0, alpha == 1 ? 3 : 5)];
  endfunction

  task automatic run_alignment(int qlen, int slen, int alpha);
    for (int i = 0; i < qlen; i++)
      send(lasf_pkg::OP_QUERY, rand_base(alpha), i == qlen - 1);
    for (int i = 0; i < slen; i++)
      send(lasf_pkg::OP_SUBJECT, rand_base(alpha), i == slen - 1);
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    in_valid <= 0;
    while (sb.pending.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (ROW_CYCLES + 4) @(posedge clk);
  endtask

  task automatic random_cfg();
    for (int r = 0; r < 4; r++) begin
      case ($urandom_range(0, 3))
        0: write_cfg(2'(r), 8'h80);
        1: write_cfg(2'(r), 8'h7F);
        default: write_cfg(2'(r), 8'($urandom_range(0, 255)));
      endcase
    end
  endtask

  initial begin
    int items;
    rst = 1;
    cfg_wr_en = 0; cfg_index = lasf_pkg::REG_MATCH; cfg_data = 0;
    in_valid = 0; in_data = '0;
    burst_left = 0; gap_left = 0;
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: defaults, N and dash handling, empty query, query dropped.
    send(lasf_pkg::OP_QUERY, "A", 1'b0);
    send(lasf_pkg::OP_QUERY, lasf_pkg::CH_ANY, 1'b0);
    send(lasf_pkg::OP_QUERY, lasf_pkg::CH_DASH, 1'b1);
    send(lasf_pkg::OP_QUERY, "C", 1'b1);  // ignored while aligning
    send(lasf_pkg::OP_SUBJECT, "A", 1'b0);
    send(lasf_pkg::OP_SUBJECT, 8'hFF, 1'b0);
    send(lasf_pkg::OP_SUBJECT, 8'h00, 1'b1);
    send(lasf_pkg::OP_SUBJECT, "G", 1'b1);  // empty query
    send(lasf_pkg::OP_QUERY, "T", 1'b0);
    send(lasf_pkg::OP_SUBJECT, "T", 1'b1);  // subject closes query
    drain();
    write_cfg(lasf_pkg::REG_MATCH, 8'h7F); write_cfg(lasf_pkg::REG_MISMATCH, 8'h80);
    write_cfg(lasf_pkg::REG_GAP, 8'h80); write_cfg(lasf_pkg::REG_GAP_OPEN, 8'h7F);
    run_alignment(4, 3, 2);
    drain();
    write_cfg(lasf_pkg::REG_GAP, 8'h7F); write_cfg(lasf_pkg::REG_GAP_OPEN, 8'h80);
    run_alignment(3, 3, 1);
    drain();
    // Saturation: large match on full-length query.
    write_cfg(lasf_pkg::REG_MATCH, 8'h7F); write_cfg(lasf_pkg::REG_GAP, 8'h7F);
    write_cfg(lasf_pkg::REG_GAP_OPEN, 8'h7F);
    run_alignment(QMAX + 2, 4, 1);  // query overflow
    drain();

    items = 0;
    while (items < 900) begin
      int ql, sl, alpha;
      random_cfg();
      if ($urandom_range(0, 3) == 0) begin
        write_cfg(lasf_pkg::REG_MATCH, 8'h02); write_cfg(lasf_pkg::REG_MISMATCH, 8'hFF);
        write_cfg(lasf_pkg::REG_GAP, 8'hFF);
        write_cfg(lasf_pkg::REG_GAP_OPEN, $urandom_range(0, 1) ? 8'h00 : 8'hFE);
      end
      for (int k = 0; k < 4; k++) begin
        ql = ($urandom_range(0, 30) == 0) ? $urandom_range(200, QMAX) : $urandom_range(0, 10);
        sl = $urandom_range(1, 8);
        alpha = $urandom_range(0, 2);
        if ($urandom_range(0, 9) == 0) begin
          // noise: stray query base while aligning
          for (int i = 0; i < ql; i++)
            send(lasf_pkg::OP_QUERY, rand_base(alpha), i == ql - 1);
          send(lasf_pkg::OP_SUBJECT, rand_base(alpha), 1'b0);
          send(lasf_pkg::OP_QUERY, rand_base(alpha), 1'($urandom_range(0, 1)));
          send(lasf_pkg::OP_SUBJECT, rand_base(alpha), 1'b1);
          items += ql + 3;
        end else begin
          run_alignment(ql, sl, alpha);
          items += ql + sl;
        end
      end
      drain();
    end

    drain();
    if (sb.errors == 0 && sb.pending.size() == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule

### sim.f
src/lasf_pkg.sv
src/lasf_cell.sv
src/local_alignment_score_fill_unit.sv
sim/tb.sv
